// ===== hdl/ile_pkg.sv =====
// Package with the shared constants and types of the indexed list engine.
package ile_pkg;

  // List size, the count width that follows from it, and the position width.
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Fixed field widths.
  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OUT_CNT_W = 7;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_READ = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TAIL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_AT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL  = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== hdl/ile_cell.sv =====
// One storage cell of the list chain: hold, load, or shift from a neighbor.
module ile_cell (
  input  logic                     clk,
  input  logic [ile_pkg::CMP_W-1:0] idx,
  input  ile_pkg::cell_ctl_t       ctl,
  input  logic [ile_pkg::VAL_W-1:0] din_val,
  input  logic [ile_pkg::VAL_W-1:0] lower_val,
  input  logic [ile_pkg::VAL_W-1:0] upper_val,
  output logic [ile_pkg::VAL_W-1:0] value,
  output logic [ile_pkg::VAL_W-1:0] rd_val
);
  import ile_pkg::*;

  logic hit;
  logic above;

  assign hit   = (idx == ctl.pos);
  assign above = (idx > ctl.pos);

  // An insert opens a gap at the position; a delete closes it from above.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above) begin
        value <= lower_val;
      end else if (hit) begin
        value <= din_val;
      end
    end else if (ctl.del && (above || hit)) begin
      value <= upper_val;
    end
  end

  // Only the addressed cell contributes to the read bus.
  assign rd_val = hit ? value : '0;

endmodule

// ===== hdl/indexed_list_engine.sv =====
// Top level of the indexed list engine: request decode, cell chain, result register.
//
// The engine takes one transaction per clock cycle: busy stays low, and the
// result of each accepted transaction appears on the result ports, marked by
// done, for exactly one cycle, in the cycle after the one that presented it.
// Every entry lives in its own cell of a chain, and inserts and deletes move
// the whole tail of the list by one place at the edge that accepts them,
// whatever the position. There is no clearing pass after reset. The
// receiver cannot stall: it must take each result in the cycle that done
// is high.
module indexed_list_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ile_pkg::REQ_W-1:0]      req_type,
  input  logic [ile_pkg::POS_W-1:0]      position,
  input  logic signed [ile_pkg::VAL_W-1:0] item_value,
  output logic                           done,
  output logic signed [ile_pkg::VAL_W-1:0] read_value,
  output logic [ile_pkg::ST_W-1:0]       status,
  output logic [ile_pkg::OUT_CNT_W-1:0]  entry_count
);
  import ile_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic             rd_ok;
  logic [ST_W-1:0]  st;
  cell_ctl_t        ctl;
  cell_ctl_t        ctl_g;
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0] rd_part  [CAPACITY];
  logic [VAL_W-1:0] rd_bus;

  assign busy  = 1'b0;
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CAP_CNT);

  // Decode the request against the current count.
  always_comb begin
    ctl        = '0;
    ctl.pos    = pos_c;
    st         = ST_DONE;
    rd_ok      = 1'b0;
    count_next = count;
    unique case (req_type)
      REQ_READ: begin
        if (pos_c < cnt_c) begin
          rd_ok = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      REQ_HEAD: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          ctl.pos = '0;
        end
      end
      REQ_TAIL: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          ctl.pos = cnt_c;
        end
      end
      REQ_AT: begin
        if (pos_c > cnt_c) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      REQ_DEL: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          ctl.del = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.del) begin
      count_next = count - 1'b1;
    end
  end

  // The chain only moves on an accepted transaction.
  always_comb begin
    ctl_g     = ctl;
    ctl_g.ins = ctl.ins & start;
    ctl_g.del = ctl.del & start;
  end

  // Row of cells wired to their neighbors; cell 0 sees item_value from below.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = item_value;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_val[i];
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    ile_cell u_cell (
      .clk       (clk),
      .idx       (CMP_W'(i)),
      .ctl       (ctl_g),
      .din_val   (item_value),
      .lower_val (lower),
      .upper_val (upper),
      .value     (cell_val[i]),
      .rd_val    (rd_part[i])
    );
  end

  // Read bus: at most one cell drives a nonzero word.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_part[k];
    end
  end

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (start) begin
      read_value  <= rd_ok ? rd_bus : '0;
      status      <= st;
      entry_count <= OUT_CNT_W'(count_next);
    end
  end

endmodule

// ===== hdl/ile_checker.sv =====
// Port-level checker for the indexed list engine, bound to the top level.
module ile_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic signed [ile_pkg::VAL_W-1:0] read_value,
  input logic [ile_pkg::ST_W-1:0]       status,
  input logic [ile_pkg::OUT_CNT_W-1:0]  entry_count
);
  import ile_pkg::*;

  localparam logic [OUT_CNT_W-1:0] CAP_OUT = OUT_CNT_W'(CAPACITY);

  // Every accepted transaction gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after an accepted transaction");

  // A result never appears without a transaction before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a transaction");

  // A full report comes only with the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CAP_OUT))
    else $error("full status with a count below capacity");

  // A failed request returns a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (read_value == '0))
    else $error("nonzero value with an error status");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .read_value  (read_value),
  .status      (status),
  .entry_count (entry_count)
);
